@@ hdl/pwdm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-thread watchdog monitor package
// Shared types and constants for the watchdog monitor front end, command
// queue and execution engine.
// ----------------------------------------------------------------------------
package pwdm_pkg;

  // Number of thread entries kept by the monitor.
  localparam int THREADS = 8;

  // Width of an entry index inside the engine.
  localparam int IdxW = (THREADS > 1) ? $clog2(THREADS) : 1;

  // Depth of the queue between the front end and the engine.
  localparam int QueueDepth = 2;

  localparam int IdW  = 3;
  localparam int ValW = 24;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SETUP  = 2'd1,
    OP_ENABLE = 2'd2,
    OP_RELOAD = 2'd3
  } op_e;

  typedef enum logic {
    KIND_REPORT  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Input transaction as seen on the port.
  typedef struct packed {
    logic [1:0]      command;
    logic [IdW-1:0]  thread_id;
    logic [ValW-1:0] timeout_value;
  } in_item_t;

  // Result transaction as seen on the port.
  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] thread_id_out;
    logic           hw_reload;
    logic           last;
  } out_item_t;

  // Classified command carried through the queue.
  typedef struct packed {
    op_e             op;
    logic [IdW-1:0]  id;
    logic [ValW-1:0] value;
  } cmd_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/per_thread_watchdog_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-thread watchdog monitor
// Software watchdog that supervises a fixed set of threads and tells, once
// per tick, whether the hardware watchdog may be reloaded.
// ----------------------------------------------------------------------------
// The monitor keeps, for each thread entry, a timeout, a countdown and an
// armed flag, all cleared by reset. Setup, enable and reload transactions
// are executed as they leave the queue; a tick leaves the queue, then
// walks every entry in index order, one entry per cycle unless a report
// waits on a stalled output, and then delivers the summary, which also
// waits while the output stalls. The walk over the shared table read port
// is why a tick holds the engine for the whole walk. A two-entry command
// queue sits between the input and the engine, so input transactions are
// taken while a tick is still being walked, until the queue is full.
// Transactions that have no effect (a thread index beyond the table, or a
// reload of entry zero) are accepted and dropped at the input. Results leave
// through a single output register: one report per expired armed entry, in
// index order, followed by a summary with last set and hw_reload telling
// whether every armed thread checked in.
module per_thread_watchdog_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwdm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwdm_pkg::out_item_t out_data_o
);

  // Queue status is shared by the front end (full) and the engine (empty).
  pwdm_pkg::q_status_t q_status;
  pwdm_pkg::cmd_t      push_data;
  pwdm_pkg::cmd_t      head;
  logic                push;
  logic                pop;

  // Front end: decodes each transaction and filters out no-op commands.
  pwdm_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: lets the input keep flowing while the engine walks a tick.
  pwdm_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Engine: owns the thread tables and produces every result transaction.
  pwdm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/pwdm_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog monitor command queue
// Small FIFO that decouples command classification from command execution.
// ----------------------------------------------------------------------------
module pwdm_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pwdm_pkg::cmd_t      push_data_i,
  input  logic                pop_i,
  output pwdm_pkg::cmd_t      head_o,
  output pwdm_pkg::q_status_t status_o
);

  localparam int PtrW = (pwdm_pkg::QueueDepth > 1) ? $clog2(pwdm_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(pwdm_pkg::QueueDepth + 1);

  pwdm_pkg::cmd_t entries_q [pwdm_pkg::QueueDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    status_o.full  = (count_q == CntW'(pwdm_pkg::QueueDepth));
    status_o.empty = (count_q == '0);
    do_push = push_i && !status_o.full;
    do_pop  = pop_i && !status_o.empty;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(pwdm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(pwdm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  assign head_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // The fill level never goes beyond the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(pwdm_pkg::QueueDepth))
    else $error("command queue overfilled");

endmodule

@@ hdl/pwdm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog monitor front end
// Accepts input transactions, decodes the command and drops those that
// cannot change any state, then pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module pwdm_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwdm_pkg::in_item_t  in_data_i,
  input  pwdm_pkg::q_status_t q_status_i,
  output logic                push_o,
  output pwdm_pkg::cmd_t      push_data_o
);

  pwdm_pkg::op_e op;
  logic          id_in_range;
  logic          keep;

  always_comb begin
    op          = pwdm_pkg::op_e'(in_data_i.command);
    id_in_range = ({29'd0, in_data_i.thread_id} < 32'(pwdm_pkg::THREADS));

    // Commands to a missing entry, and reloads of entry zero, have no effect.
    unique case (op)
      pwdm_pkg::OP_TICK:   keep = 1'b1;
      pwdm_pkg::OP_RELOAD: keep = id_in_range && (in_data_i.thread_id != '0);
      default:             keep = id_in_range;
    endcase

    in_stall_o        = q_status_i.full;
    push_o            = in_valid_i && !q_status_i.full && keep;
    push_data_o.op    = op;
    push_data_o.id    = in_data_i.thread_id;
    push_data_o.value = in_data_i.timeout_value;
  end

endmodule

@@ hdl/pwdm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Watchdog monitor execution engine
// Holds the per-thread tables, executes queued commands and, on a tick,
// walks the entries, one per cycle when not stalled, into a result register.
// ----------------------------------------------------------------------------
module pwdm_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwdm_pkg::cmd_t       head_i,
  input  pwdm_pkg::q_status_t  q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pwdm_pkg::out_item_t  out_data_o
);

  localparam int IdxW = pwdm_pkg::IdxW;
  localparam int ValW = pwdm_pkg::ValW;
  localparam int IdW  = pwdm_pkg::IdW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_SUM  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ValW-1:0] limit_q     [pwdm_pkg::THREADS];
  logic [ValW-1:0] remaining_q [pwdm_pkg::THREADS];
  logic [pwdm_pkg::THREADS-1:0] armed_q;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            all_in_q, all_in_d;

  logic                out_valid_q, out_valid_d;
  pwdm_pkg::out_item_t out_q, out_d;
  logic                out_load, out_ready;

  logic [IdxW-1:0] cur_idx;
  logic [ValW-1:0] lim_rd, rem_rd, rem_dec;
  logic            expired;

  logic            lim_we, rem_we, arm_we;
  logic [ValW-1:0] lim_wdata, rem_wdata;

  always_comb begin
    out_ready = !out_valid_q || !out_stall_i;
    cur_idx   = (state_q == ST_WALK) ? idx_q : IdxW'(head_i.id);
    lim_rd    = limit_q[cur_idx];
    rem_rd    = remaining_q[cur_idx];
    rem_dec   = (rem_rd != '0) ? rem_rd - 1'b1 : rem_rd;
    expired   = armed_q[cur_idx] && ((rem_dec == '0) || (rem_dec > lim_rd));

    state_d   = state_q;
    idx_d     = idx_q;
    all_in_d  = all_in_q;
    pop_o     = 1'b0;
    lim_we    = 1'b0;
    rem_we    = 1'b0;
    arm_we    = 1'b0;
    lim_wdata = head_i.value;
    rem_wdata = head_i.value;
    out_load  = 1'b0;
    out_d     = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          unique case (head_i.op)
            pwdm_pkg::OP_TICK: begin
              idx_d    = '0;
              all_in_d = 1'b1;
              state_d  = ST_WALK;
            end
            pwdm_pkg::OP_SETUP: begin
              lim_we = 1'b1;
              rem_we = 1'b1;
            end
            pwdm_pkg::OP_ENABLE: begin
              arm_we = 1'b1;
            end
            pwdm_pkg::OP_RELOAD: begin
              rem_we    = armed_q[cur_idx];
              rem_wdata = lim_rd;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // An expired entry needs the result stage; otherwise move on at once.
        if (!expired || out_ready) begin
          rem_we    = armed_q[cur_idx];
          rem_wdata = rem_dec;
          if (expired) begin
            out_load            = 1'b1;
            out_d.kind          = pwdm_pkg::KIND_REPORT;
            out_d.thread_id_out = IdW'(idx_q);
            out_d.hw_reload     = 1'b0;
            out_d.last          = 1'b0;
            all_in_d            = 1'b0;
          end
          if (idx_q == IdxW'(pwdm_pkg::THREADS - 1)) begin
            state_d = ST_SUM;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_SUM: begin
        if (out_ready) begin
          out_load            = 1'b1;
          out_d.kind          = pwdm_pkg::KIND_SUMMARY;
          out_d.thread_id_out = '0;
          out_d.hw_reload     = all_in_q;
          out_d.last          = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      all_in_q    <= 1'b1;
      out_valid_q <= 1'b0;
      armed_q     <= '0;
      for (int i = 0; i < pwdm_pkg::THREADS; i++) begin
        limit_q[i]     <= '0;
        remaining_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      all_in_q    <= all_in_d;
      out_valid_q <= out_valid_d;
      if (lim_we) begin
        limit_q[cur_idx] <= lim_wdata;
      end
      if (rem_we) begin
        remaining_q[cur_idx] <= rem_wdata;
      end
      if (arm_we) begin
        armed_q[cur_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Reports and the summary differ in their kind and last flags; a report never sets hw_reload.
  a_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.kind == out_q.last) && (out_q.kind || !out_q.hw_reload))
    else $error("malformed watchdog result");

  // The walk index never leaves the entry range.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ({{(32-IdxW){1'b0}}, idx_q} < 32'(pwdm_pkg::THREADS)))
    else $error("walk index out of range");

  // A delivered summary returns the engine to idle.
  a_sum_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) && out_ready |=> (state_q == ST_IDLE) && out_valid_q && out_q.last)
    else $error("summary did not close the tick");

  // Commands are only taken from the queue while idle.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE) && !q_status_i.empty)
    else $error("queue popped outside idle");

endmodule
